>>> rtl/core/n2a_pkg.sv
// Shared types, constants and helpers for the number to ASCII formatter.
`default_nettype none

package n2a_pkg;

  localparam int unsigned ValueW        = 32;
  localparam int unsigned OpW           = 3;
  localparam int unsigned CharW         = 7;
  localparam int unsigned LoW           = 16;
  localparam int unsigned DigitsN       = 10;
  localparam int unsigned BcdW          = DigitsN * 4;
  localparam int unsigned StepsPerStage = 8;
  localparam int unsigned StagesN       = ValueW / StepsPerStage;
  localparam int unsigned PosW          = 4;

  typedef enum logic [OpW-1:0] {
    OP_BIN  = 3'd0,
    OP_DEC  = 3'd1,
    OP_GRP  = 3'd2,
    OP_HEXB = 3'd3,
    OP_HEXW = 3'd4
  } op_e;

  // One item on its way through the conversion pipe.
  typedef struct packed {
    op_e               op;
    logic [LoW-1:0]    lo;
    logic [BcdW-1:0]   bcd;
    logic [ValueW-1:0] bin;
  } dd_t;

  localparam logic [CharW-1:0] ChZero  = 7'h30;
  localparam logic [CharW-1:0] ChOne   = 7'h31;
  localparam logic [CharW-1:0] ChB     = 7'h62;
  localparam logic [CharW-1:0] ChX     = 7'h78;
  localparam logic [CharW-1:0] ChComma = 7'h2C;
  localparam logic [CharW-1:0] ChAlpha = 7'h37;  // 'A' minus ten

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] c;
    if (nib < 4'd10) begin
      c = ChZero + {3'b000, nib};
    end else begin
      c = ChAlpha + {3'b000, nib};
    end
    return c;
  endfunction

  // Digit counts that open a new thousands group.
  function automatic logic group_edge(input logic [PosW-1:0] k);
    logic r;
    case (k)
      4'd3, 4'd6, 4'd9: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/n2a_if.sv
// Channel interfaces: item input, character output and configuration write.
`default_nettype none

interface n2a_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] value;
  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

interface n2a_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last_char;
  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface n2a_cfg_if;
  logic valid;
  logic ready;
  logic quiet;
  modport source (output valid, output quiet, input ready);
  modport sink (input valid, input quiet, output ready);
endinterface

`default_nettype wire

>>> rtl/core/n2a_dabble.sv
// One pipeline stage of the binary to BCD shift-and-add-three conversion.
`default_nettype none

module n2a_dabble (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  n2a_pkg::dd_t  data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output n2a_pkg::dd_t  data_o
);
  import n2a_pkg::*;

  logic [BcdW+ValueW-1:0] sh;
  dd_t                    next;
  logic                   valid_q;
  dd_t                    data_q;

  always_comb begin
    sh = {data_i.bcd, data_i.bin};
    for (int s = 0; s < StepsPerStage; s++) begin
      for (int g = 0; g < DigitsN; g++) begin
        if (sh[ValueW+4*g +: 4] >= 4'd5) begin
          sh[ValueW+4*g +: 4] = sh[ValueW+4*g +: 4] + 4'd3;
        end
      end
      sh = sh << 1;
    end
    next     = data_i;
    next.bcd = sh[BcdW+ValueW-1:ValueW];
    next.bin = sh[ValueW-1:0];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= next;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

>>> rtl/core/n2a_emit.sv
// Character serializer: walks one converted item and drives the output register.
`default_nettype none

module n2a_emit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  n2a_pkg::dd_t                data_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [n2a_pkg::CharW-1:0]   char_o,
  output logic                        last_o
);
  import n2a_pkg::*;

  logic             busy_q;
  op_e              op_q;
  logic [LoW-1:0]   lo_q;
  logic [BcdW-1:0]  bcd_q;
  logic [PosW-1:0]  nd_q;
  logic [PosW-1:0]  pos_q;
  logic             comma_q;
  logic             ov_q;
  logic [CharW-1:0] char_q;
  logic             last_q;

  logic [PosW-1:0]  nd_c;
  logic             dec_c;
  logic             fire;
  logic             load;
  logic [CharW-1:0] ch_c;
  logic             last_c;
  logic [PosW-1:0]  pos_n;
  logic             comma_n;
  logic [3:0]       dig [DigitsN];
  logic [PosW-1:0]  dig_idx;
  logic [2:0]       bit_idx;
  logic [1:0]       nib_idx;
  logic [3:0]       nib;

  // Count significant digits of the incoming BCD word, at least one.
  always_comb begin
    nd_c = PosW'(1);
    for (int g = 0; g < DigitsN; g++) begin
      if (data_i.bcd[4*g +: 4] != 4'd0) begin
        nd_c = PosW'(g + 1);
      end
    end
  end

  assign dec_c = (data_i.op == OP_DEC) || (data_i.op == OP_GRP);

  always_comb begin
    for (int g = 0; g < DigitsN; g++) begin
      dig[g] = bcd_q[4*g +: 4];
    end
  end

  assign dig_idx = pos_q - PosW'(1);
  assign bit_idx = 3'(4'd9 - pos_q);
  assign nib_idx = (op_q == OP_HEXB) ? 2'(4'd3 - pos_q) : 2'(4'd5 - pos_q);
  assign nib     = lo_q[{nib_idx, 2'b00} +: 4];

  always_comb begin
    ch_c    = ChZero;
    last_c  = 1'b0;
    pos_n   = pos_q + PosW'(1);
    comma_n = 1'b0;
    case (op_q)
      OP_BIN: begin
        if (pos_q == 4'd0) begin
          ch_c = ChZero;
        end else if (pos_q == 4'd1) begin
          ch_c = ChB;
        end else begin
          ch_c = lo_q[bit_idx] ? ChOne : ChZero;
        end
        last_c = (pos_q == 4'd9);
      end
      OP_HEXB, OP_HEXW: begin
        if (pos_q == 4'd0) begin
          ch_c = ChZero;
        end else if (pos_q == 4'd1) begin
          ch_c = ChX;
        end else begin
          ch_c = hex_char(nib);
        end
        last_c = (op_q == OP_HEXB) ? (pos_q == 4'd3) : (pos_q == 4'd5);
      end
      OP_DEC, OP_GRP: begin
        // pos_q counts remaining digits; a comma precedes each group but the first
        if (op_q == OP_GRP && pos_q != nd_q && group_edge(pos_q) && !comma_q) begin
          ch_c    = ChComma;
          pos_n   = pos_q;
          comma_n = 1'b1;
        end else begin
          ch_c   = ChZero + {3'b000, dig[dig_idx]};
          last_c = (pos_q == 4'd1);
          pos_n  = pos_q - PosW'(1);
        end
      end
      default: begin
        last_c = 1'b1;
      end
    endcase
  end

  assign fire    = busy_q && (!ov_q || ready_i);
  assign ready_o = !busy_q || (fire && last_c);
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      pos_q   <= '0;
      comma_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      if (load) begin
        busy_q  <= 1'b1;
        pos_q   <= dec_c ? nd_c : '0;
        comma_q <= 1'b0;
      end else if (fire && last_c) begin
        busy_q <= 1'b0;
      end else if (fire) begin
        pos_q   <= pos_n;
        comma_q <= comma_n;
      end
      if (fire) begin
        ov_q <= 1'b1;
      end else if (ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q  <= data_i.op;
      lo_q  <= data_i.lo;
      bcd_q <= data_i.bcd;
      nd_q  <= nd_c;
    end
    if (fire) begin
      char_q <= ch_c;
      last_q <= last_c;
    end
  end

  assign valid_o = ov_q;
  assign char_o  = char_q;
  assign last_o  = last_q;

  a_dec_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (op_q == OP_DEC || op_q == OP_GRP) |-> pos_q != 4'd0 && pos_q <= nd_q)
    else $error("digit counter out of range");

  a_bin_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && op_q == OP_BIN |-> pos_q <= 4'd9)
    else $error("binary position out of range");

  a_comma_grouped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && comma_q |-> op_q == OP_GRP)
    else $error("comma flag set outside grouped decimal");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && last_c && !valid_i |=> !busy_q)
    else $error("serializer stays busy after last beat");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !ready_i |=> ov_q && $stable(char_q) && $stable(last_q))
    else $error("stalled output beat changed");

endmodule

`default_nettype wire

>>> rtl/core/number_to_ascii_formatter_top.sv
// Top level: entry filter, four-stage BCD conversion pipe and character serializer.
// An item passes the dabble stage registers, then the serializer's output register.
// Throughput: the pipe takes an item every cycle unless back-pressure holds it; the
//   serializer sends one character per cycle while out ready allows, 1 to 13 per item.
// Items with quiet set or an unused format are accepted at the door and produce nothing.
// Reset clears the quiet register, all stage valid bits and the serializer state.
`default_nettype none

module number_to_ascii_formatter_top (
  input  logic   clk_i,
  input  logic   rst_ni,
  n2a_cfg_if.sink   cfg_i,
  n2a_in_if.sink    in_i,
  n2a_out_if.source out_o
);
  import n2a_pkg::*;

  logic quiet_q;
  logic drop;
  logic vld [StagesN+1];
  logic rdy [StagesN+1];
  dd_t  dat [StagesN+1];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_q <= 1'b0;
    end else if (cfg_i.valid) begin
      quiet_q <= cfg_i.quiet;
    end
  end

  // Drop quiet items and unused formats at the door.
  assign drop       = quiet_q || (in_i.op > OP_HEXW);
  assign in_i.ready = drop || rdy[0];
  assign vld[0]     = in_i.valid && !drop;

  always_comb begin
    dat[0].op  = op_e'(in_i.op);
    dat[0].lo  = in_i.value[LoW-1:0];
    dat[0].bcd = '0;
    dat[0].bin = in_i.value;
  end

  for (genvar s = 0; s < StagesN; s++) begin : g_stage
    n2a_dabble u_dabble (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[s]),
      .ready_o (rdy[s]),
      .data_i  (dat[s]),
      .valid_o (vld[s+1]),
      .ready_i (rdy[s+1]),
      .data_o  (dat[s+1])
    );
  end

  n2a_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[StagesN]),
    .ready_o (rdy[StagesN]),
    .data_i  (dat[StagesN]),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .char_o  (out_o.char_code),
    .last_o  (out_o.last_char)
  );

endmodule

`default_nettype wire
